@@ hw/rtl/sip_header_preparser_defines.svh @@
// assertion macros used by the checker file shp_checker.sv
`ifndef SIP_HEADER_PREPARSER_DEFINES_SVH
`define SIP_HEADER_PREPARSER_DEFINES_SVH

// same-cycle implication, off during reset
`define SHP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SHP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, always on
`define SHP_ASSERT_NXT_ND(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/shp_pkg.sv @@
package shp_pkg;

  localparam longint SHP_MAX_MSG_BYTES = 65536;
  localparam logic [15:0] SHP_OFFS_TOP = (SHP_MAX_MSG_BYTES - 1 > 65535) ? 16'hFFFF :
                                         16'(SHP_MAX_MSG_BYTES - 1);

  // result buffer depth, room for the two results of one item on top of two already held
  localparam int SHP_RES_DEPTH = 4;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [4:0] {
    ST_NEWMSG        = 5'd0,
    ST_NEWMSGCRLF    = 5'd1,
    ST_STARTLINE     = 5'd2,
    ST_STARTLINECRLF = 5'd3,
    ST_BUILDHDR      = 5'd4,
    ST_EWSPOSTHDR    = 5'd5,
    ST_EWSPOSTCOLON  = 5'd6,
    ST_BUILDDATA     = 5'd7,
    ST_BUILDDATACRLF = 5'd8,
    ST_CHECKCONT     = 5'd9,
    ST_CHECKENDHDR   = 5'd10,
    ST_INQ           = 5'd11,
    ST_INQESC        = 5'd12,
    ST_INANG         = 5'd13,
    ST_INANGQ        = 5'd14,
    ST_INANGQESC     = 5'd15,
    ST_DONE          = 5'd16
  } shp_state_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_FLINE   = 3'd1,
    EV_NAME    = 3'd2,
    EV_VALUE   = 3'd3,
    EV_END     = 3'd4,
    EV_BAD     = 3'd5,
    EV_IGNORED = 3'd6
  } shp_event_t;

  typedef struct packed {
    shp_event_t  event_res;
    logic [15:0] span_begin;
    logic [15:0] span_end;
    logic [15:0] name_begin;
    logic [15:0] name_end;
    logic        last;
  } res_t;

  function automatic logic [15:0] shp_offs_inc(logic [15:0] p);
    return (p >= SHP_OFFS_TOP) ? SHP_OFFS_TOP : p + 16'd1;
  endfunction

endpackage

@@ hw/rtl/shp_in_if.sv @@
interface shp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_msg;
  logic       header_is_list;

  modport source (output valid, data_byte, start_msg, header_is_list, input ready);
  modport sink (input valid, data_byte, start_msg, header_is_list, output ready);
endinterface

@@ hw/rtl/shp_out_if.sv @@
interface shp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [15:0] span_begin;
  logic [15:0] span_end;
  logic [15:0] name_begin;
  logic [15:0] name_end;
  logic        last;

  modport source (output valid, event_res, span_begin, span_end, name_begin, name_end, last,
                  input ready);
  modport sink (input valid, event_res, span_begin, span_end, name_begin, name_end, last,
                output ready);
endinterface

@@ hw/rtl/sip_header_preparser.sv @@
// an item's results enter the result buffer when it is accepted and queue behind held ones
// one item per cycle via table and offset update while the buffer holds at most two results
// an item that ends a value and starts a header with its colon gives two results,
// which leave one after the other; the 4-entry result buffer absorbs them
// reset (rst_n low, synchronous): new-message state, offsets zero, result buffer empty
module sip_header_preparser
  import shp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  shp_in_if.sink    in_ch,
  shp_out_if.source out_ch
);

  localparam int PTR_W = $clog2(SHP_RES_DEPTH);
  localparam int CNT_W = $clog2(SHP_RES_DEPTH + 1);

  typedef struct packed {
    shp_state_t  st;
    logic        comma;
    logic [15:0] ab;
    logic [15:0] ae;
    logic [15:0] nb;
    logic [15:0] ne;
    logic        fin;
  } ctx_t;

  typedef struct packed {
    shp_state_t nxt;
    logic       add;
    logic       back;
    logic       fline;
    logic       clr;
    logic       hdr;
    logic       data;
    logic       bad;
    logic       done;
  } trans_t;

  typedef struct packed {
    ctx_t cx;
    logic has;
    res_t res;
    logic back;
  } run_t;

  function automatic trans_t trans_lookup(shp_state_t st, logic comma, logic [7:0] c);
    trans_t t;
    logic   lws;
    t   = '0;
    lws = (c == CH_SP) || (c == CH_TAB);
    case (st)
      ST_NEWMSG: begin
        if (c == CH_CR) t.nxt = ST_NEWMSGCRLF;
        else begin
          t.add = 1'b1;
          t.nxt = ST_STARTLINE;
        end
      end
      ST_NEWMSGCRLF: begin
        if (c == CH_LF) t.nxt = ST_NEWMSG;
        else begin
          t.bad = 1'b1;
          t.nxt = ST_DONE;
        end
      end
      ST_STARTLINE: begin
        if (c == CH_CR) t.nxt = ST_STARTLINECRLF;
        else begin
          t.add = 1'b1;
          t.nxt = ST_STARTLINE;
        end
      end
      ST_STARTLINECRLF: begin
        if (c == CH_LF) begin
          t.clr   = 1'b1;
          t.fline = 1'b1;
          t.nxt   = ST_BUILDHDR;
        end else begin
          t.bad = 1'b1;
          t.nxt = ST_DONE;
        end
      end
      ST_BUILDHDR: begin
        if (lws) t.nxt = ST_EWSPOSTHDR;
        else if (c == CH_COLON) begin
          t.hdr = 1'b1;
          t.clr = 1'b1;
          t.nxt = ST_EWSPOSTCOLON;
        end else begin
          t.add = 1'b1;
          t.nxt = ST_BUILDHDR;
        end
      end
      ST_EWSPOSTHDR: begin
        if (lws) t.nxt = ST_EWSPOSTHDR;
        else if (c == CH_COLON) begin
          t.hdr = 1'b1;
          t.clr = 1'b1;
          t.nxt = ST_EWSPOSTCOLON;
        end else begin
          t.bad = 1'b1;
          t.nxt = ST_DONE;
        end
      end
      ST_EWSPOSTCOLON: begin
        if (lws) begin
          t.clr = 1'b1;
          t.nxt = ST_EWSPOSTCOLON;
        end else begin
          t.add = 1'b1;
          t.nxt = ST_BUILDDATA;
        end
      end
      ST_BUILDDATA: begin
        t.add = 1'b1;
        t.nxt = ST_BUILDDATA;
        if (c == CH_CR) begin
          t.add = 1'b0;
          t.nxt = ST_BUILDDATACRLF;
        end else if (comma && c == CH_LT) t.nxt = ST_INANG;
        else if (comma && c == CH_DQUOTE) t.nxt = ST_INQ;
        else if (comma && c == CH_COMMA) begin
          t.add  = 1'b0;
          t.data = 1'b1;
          t.clr  = 1'b1;
          t.nxt  = ST_EWSPOSTCOLON;
        end
      end
      ST_BUILDDATACRLF: begin
        if (c == CH_LF) t.nxt = ST_CHECKCONT;
        else begin
          t.bad = 1'b1;
          t.nxt = ST_DONE;
        end
      end
      ST_CHECKCONT: begin
        if (lws) begin
          t.add = 1'b1;
          t.nxt = ST_BUILDDATA;
        end else if (c == CH_CR) begin
          t.data = 1'b1;
          t.clr  = 1'b1;
          t.nxt  = ST_CHECKENDHDR;
        end else begin
          // value ends, this byte opens the next header name
          t.data = 1'b1;
          t.clr  = 1'b1;
          t.back = 1'b1;
          t.nxt  = ST_BUILDHDR;
        end
      end
      ST_CHECKENDHDR: begin
        t.nxt = ST_DONE;
        if (c == CH_LF) t.done = 1'b1;
        else t.bad = 1'b1;
      end
      ST_INANG: begin
        t.add = 1'b1;
        if (c == CH_GT) t.nxt = ST_BUILDDATA;
        else if (c == CH_DQUOTE) t.nxt = ST_INANGQ;
        else t.nxt = ST_INANG;
      end
      ST_INANGQ: begin
        t.add = 1'b1;
        if (c == CH_DQUOTE) t.nxt = ST_INANG;
        else if (c == CH_BSLASH) t.nxt = ST_INANGQESC;
        else t.nxt = ST_INANGQ;
      end
      ST_INANGQESC: begin
        t.add = 1'b1;
        t.nxt = ST_INANGQ;
      end
      ST_INQ: begin
        t.add = 1'b1;
        if (c == CH_DQUOTE) t.nxt = ST_BUILDDATA;
        else if (c == CH_BSLASH) t.nxt = ST_INQESC;
        else t.nxt = ST_INQ;
      end
      ST_INQESC: begin
        t.add = 1'b1;
        t.nxt = ST_INQ;
      end
      default: t.nxt = ST_NEWMSG;
    endcase
    return t;
  endfunction

  function automatic run_t run_edge(ctx_t cx, logic [7:0] c, logic [15:0] p);
    run_t   r;
    trans_t t;
    t      = trans_lookup(cx.st, cx.comma, c);
    r.cx   = cx;
    r.has  = 1'b0;
    r.res  = '0;
    r.back = t.back;
    if (t.add) r.cx.ae = p;
    if (t.hdr) begin
      r.cx.nb              = r.cx.ab;
      r.cx.ne              = r.cx.ae;
      r.has                = 1'b1;
      r.res.event_res      = EV_NAME;
      r.res.span_begin     = r.cx.ab;
      r.res.span_end       = r.cx.ae;
    end else if (t.data) begin
      r.has                = 1'b1;
      r.res.event_res      = EV_VALUE;
      r.res.span_begin     = r.cx.ab;
      r.res.span_end       = r.cx.ae;
      r.res.name_begin     = r.cx.nb;
      r.res.name_end       = r.cx.ne;
    end else if (t.fline) begin
      r.has                = 1'b1;
      r.res.event_res      = EV_FLINE;
      r.res.span_begin     = r.cx.ab;
      r.res.span_end       = r.cx.ae;
    end else if (t.bad) begin
      r.cx.fin             = 1'b1;
      r.has                = 1'b1;
      r.res.event_res      = EV_BAD;
      r.res.span_begin     = p;
      r.res.span_end       = p;
    end else if (t.done) begin
      r.cx.fin             = 1'b1;
      r.has                = 1'b1;
      r.res.event_res      = EV_END;
      r.res.span_begin     = r.cx.ab;
      r.res.span_end       = r.cx.ae;
    end
    r.cx.st = t.nxt;
    if (t.clr) begin
      r.cx.ab = t.back ? p : shp_offs_inc(p);
      r.cx.ae = r.cx.ab;
    end
    return r;
  endfunction

  ctx_t              ctx_r, ctx_nxt;
  logic [15:0]       offs_r, offs_nxt;
  res_t              fifo_r [SHP_RES_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, wr_ptr_inc;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic        in_fire, out_fire;
  ctx_t        cx0, cxa, cxb;
  logic [15:0] p;
  run_t        r1, r2;
  logic        two;
  res_t        res_a, res_b;
  logic [1:0]  push_n;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r <= CNT_W'(SHP_RES_DEPTH - 2));

  // one byte through the table, plus the look-back pass from the header-name state
  always_comb begin
    if (in_ch.start_msg) begin
      cx0 = '0;
      p   = '0;
    end else begin
      cx0 = ctx_r;
      p   = offs_r;
    end
    cxa = cx0;
    if ((cx0.st == ST_BUILDHDR || cx0.st == ST_EWSPOSTHDR) && in_ch.data_byte == CH_COLON)
      cxa.comma = in_ch.header_is_list;
    r1  = run_edge(cxa, in_ch.data_byte, p);
    cxb = r1.cx;
    if (cxb.st == ST_BUILDHDR && in_ch.data_byte == CH_COLON)
      cxb.comma = in_ch.header_is_list;
    r2  = run_edge(cxb, in_ch.data_byte, p);
    two = r1.back && !r1.cx.fin;
  end

  // next state
  always_comb begin
    ctx_nxt  = ctx_r;
    offs_nxt = offs_r;
    if (in_fire) begin
      if (cx0.fin) ctx_nxt = cx0;
      else begin
        ctx_nxt  = two ? r2.cx : r1.cx;
        offs_nxt = shp_offs_inc(p);
      end
    end
  end

  // results of this item
  always_comb begin
    res_a  = '0;
    res_b  = '0;
    push_n = 2'd1;
    if (cx0.fin) begin
      res_a.event_res = EV_IGNORED;
      res_a.last      = 1'b1;
    end else if (r1.has && two && r2.has) begin
      res_a      = r1.res;
      res_b      = r2.res;
      res_b.last = 1'b1;
      push_n     = 2'd2;
    end else if (r1.has) begin
      res_a      = r1.res;
      res_a.last = 1'b1;
    end else if (two && r2.has) begin
      res_a      = r2.res;
      res_a.last = 1'b1;
    end else begin
      res_a.event_res = EV_NONE;
      res_a.last      = 1'b1;
    end
  end

  assign wr_ptr_inc = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (in_fire) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
      cnt_nxt    = cnt_nxt + CNT_W'(push_n);
    end
    if (out_fire) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
      cnt_nxt    = cnt_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r    <= '0;
      offs_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      ctx_r    <= ctx_nxt;
      offs_r   <= offs_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fifo_r[wr_ptr_r] <= res_a;
      if (push_n == 2'd2) fifo_r[wr_ptr_inc] <= res_b;
    end
  end

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.event_res  = fifo_r[rd_ptr_r].event_res;
  assign out_ch.span_begin = fifo_r[rd_ptr_r].span_begin;
  assign out_ch.span_end   = fifo_r[rd_ptr_r].span_end;
  assign out_ch.name_begin = fifo_r[rd_ptr_r].name_begin;
  assign out_ch.name_end   = fifo_r[rd_ptr_r].name_end;
  assign out_ch.last       = fifo_r[rd_ptr_r].last;

endmodule

@@ hw/rtl/shp_checker.sv @@
`include "sip_header_preparser_defines.svh"

module shp_checker
  import shp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_res,
  input logic [15:0] out_span_begin,
  input logic [15:0] out_span_end,
  input logic        out_last
);

  `SHP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SHP_ASSERT_NXT_ND(a_rst_empty, clk, !rst_n, !out_valid, "result offered right after reset")
  `SHP_ASSERT_NXT(a_item_result, clk, rst_n, in_valid && in_ready, out_valid, "accepted item gave no result")
  `SHP_ASSERT_NXT(a_pair_follows, clk, rst_n, out_valid && !out_last, out_valid, "second result of an item missing")
  `SHP_ASSERT_IMP(a_ignored_form, clk, rst_n, out_valid && out_event_res == EV_IGNORED, out_last && out_span_begin == 16'd0 && out_span_end == 16'd0, "ignored result not single or not zero")

endmodule

bind sip_header_preparser shp_checker u_shp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_event_res  (out_ch.event_res),
  .out_span_begin (out_ch.span_begin),
  .out_span_end   (out_ch.span_end),
  .out_last       (out_ch.last)
);
